@@ sv/lzw_variable_width_compressor_macros.svh @@
// Assertion macros shared by the LZW compressor RTL.
`ifndef LZW_VARIABLE_WIDTH_COMPRESSOR_MACROS_SVH
`define LZW_VARIABLE_WIDTH_COMPRESSOR_MACROS_SVH

// Same-cycle implication.
`define LZWVW_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define LZWVW_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/lzwvw_pkg.sv @@
// Types and constants shared by the LZW compressor modules.
package lzwvw_pkg;

   localparam int START_WIDTH = 9;
   localparam int FIRST_FREE  = 256;

   localparam logic [1:0] KIND_DATA  = 2'd0;
   localparam logic [1:0] KIND_RESET = 2'd1;
   localparam logic [1:0] KIND_END   = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_SLOT_RD,
      ST_CODE_RD,
      ST_CHECK,
      ST_EMIT_RST,
      ST_FLUSH,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      EMIT_NONE,
      EMIT_PREFIX,
      EMIT_RESET,
      EMIT_END
   } emit_sel_type;

   typedef struct packed {
      logic         start;      // latch input transaction
      logic         first;      // first byte becomes prefix
      logic         probe;      // form key, hash to home slot
      logic         slot_rd;    // read slot table
      logic         code_rd;    // read code table
      logic         next_slot;  // linear probe step
      logic         take_hit;   // prefix <= matched code
      logic         insert;     // learn entry, advance code counter
      logic         restart;    // back to start-of-stream state
      emit_sel_type emit;
      logic         emit_last;
   } cmd_type;

   typedef struct packed {
      logic present;
      logic fin;
      logic hit;
      logic empty;
      logic will_clear;
      logic out_free;
   } status_type;

endpackage

@@ sv/lzw_variable_width_compressor.sv @@
// Top level of the variable code width LZW compressor.
// Input stream: one byte per transaction on req_tdata[7:0]; req_tlast marks the final byte.
// Output stream: one code per transaction; rsp_tlast marks the last code caused by a byte.
// A byte is latched and passes the start state to reach the dictionary, then each hash probe
// reads the slot table, reads the code table and compares; typical load needs one or two probes.
// Codes go out one per cycle when the sink is ready,
// up to four per byte (data, dictionary reset, flush, end of stream).
// A byte's first code is loaded once its probe resolves and the output register is free.
// The probe loop over the single-port dictionary sets the rate.
// A new byte is taken once the sequencer is idle, even if a code still waits in the
// output register; a stalled sink holds the code and stops the sequencer at its next emit.
// Reset: prefix cleared, next code 256, width 9, limit register 12, dictionary empty.
// The dictionary needs no clearing pass: slots count as live only for codes issued
// since the last stream or dictionary reset, so reset and clears write nothing to the memories.
// CSR: one register, max_code_width at byte address 0, clamped to 9..MAX_WIDTH.
// Write it only while the block is idle.
module lzw_variable_width_compressor
   import lzwvw_pkg::*;
#(
   parameter int MAX_WIDTH  = 12,
   parameter int DICT_DEPTH = 4096,
   localparam int RSP_W = ((MAX_WIDTH + 4 + 7) / 8) * 8
)(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,   // data_byte[7:0]
   input  logic             req_tlast,   // final_byte
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,   // code_value, code_bits, zero pad
   output logic [1:0]       rsp_tuser,   // code_kind
   output logic             rsp_tlast,   // run_end
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [2:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

`include "lzw_variable_width_compressor_macros.svh"

   localparam int WW = $clog2(MAX_WIDTH + 1);

   logic [3:0]           max_width_ff;
   logic [3:0]           max_width_in;
   logic [WW-1:0]        limit;
   cmd_type              cmd;
   status_type           status;
   logic [MAX_WIDTH-1:0] code_value;
   logic [3:0]           code_bits;

   // APB register; address bit 2 selects the register index.
   assign csr_pready = 1'b1;

   always_comb begin
      max_width_in = max_width_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && (csr_paddr[2] == 1'b0)) begin
         max_width_in = csr_pwdata[3:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_width_ff <= 4'd12;
      end else begin
         max_width_ff <= max_width_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == 1'b0) ? {28'd0, max_width_ff} : 32'd0;

   // Effective limit clamped to the supported width range.
   always_comb begin
      priority if (WW'(max_width_ff) < WW'(START_WIDTH)) begin
         limit = WW'(START_WIDTH);
      end else if ((WW + 1)'(max_width_ff) > (WW + 1)'(MAX_WIDTH)) begin
         limit = WW'(MAX_WIDTH);
      end else begin
         limit = WW'(max_width_ff);
      end
   end

   lzwvw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   lzwvw_dpath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .DICT_DEPTH (DICT_DEPTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .in_byte    (req_tdata),
      .in_fin     (req_tlast),
      .limit      (limit),
      .cmd        (cmd),
      .status     (status),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_value  (code_value),
      .rsp_bits   (code_bits),
      .rsp_kind   (rsp_tuser),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = RSP_W'({code_bits, code_value});

   // An accepted byte leaves the sequencer busy in the cycle after it is taken.
   `LZWVW_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready, "input taken while sequencer busy")
   // End-of-stream code always closes the run of its byte.
   `LZWVW_ASSERT_NOW(a_end_is_last, clock, reset, rsp_tvalid && (rsp_tuser == KIND_END), rsp_tlast, "end code without run end")
   // Dictionary reset code is 2^width-2, always even.
   `LZWVW_ASSERT_NOW(a_reset_code_even, clock, reset, rsp_tvalid && (rsp_tuser == KIND_RESET), !code_value[0], "odd reset code")

endmodule

@@ sv/lzwvw_ctrl.sv @@
// Sequencer for the LZW compressor: lookup, insert and code emission order.
module lzwvw_ctrl
   import lzwvw_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.emit   = EMIT_NONE;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.start = 1'b1;
               state_in  = ST_START;
            end
         end
         ST_START: begin
            if (!status.present) begin
               cmd.first = 1'b1;
               state_in  = status.fin ? ST_FLUSH : ST_IDLE;
            end else begin
               cmd.probe = 1'b1;
               state_in  = ST_SLOT_RD;
            end
         end
         ST_SLOT_RD: begin
            cmd.slot_rd = 1'b1;
            state_in    = ST_CODE_RD;
         end
         ST_CODE_RD: begin
            cmd.code_rd = 1'b1;
            state_in    = ST_CHECK;
         end
         ST_CHECK: begin
            priority if (status.hit) begin
               cmd.take_hit = 1'b1;
               state_in     = status.fin ? ST_FLUSH : ST_IDLE;
            end else if (!status.empty) begin
               cmd.next_slot = 1'b1;
               state_in      = ST_SLOT_RD;
            end else if (status.out_free) begin
               cmd.insert    = 1'b1;
               cmd.emit      = EMIT_PREFIX;
               cmd.emit_last = !status.fin && !status.will_clear;
               priority if (status.will_clear) begin
                  state_in = ST_EMIT_RST;
               end else if (status.fin) begin
                  state_in = ST_FLUSH;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               // output register still full: hold the miss until it drains
               state_in = ST_CHECK;
            end
         end
         ST_EMIT_RST: begin
            if (status.out_free) begin
               cmd.emit      = EMIT_RESET;
               cmd.emit_last = !status.fin;
               state_in      = status.fin ? ST_FLUSH : ST_IDLE;
            end
         end
         ST_FLUSH: begin
            if (status.out_free) begin
               cmd.emit = EMIT_PREFIX;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.emit      = EMIT_END;
               cmd.emit_last = 1'b1;
               cmd.restart   = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ sv/lzwvw_dpath.sv @@
// Datapath of the LZW compressor: stream state, hashed dictionary, output register.
module lzwvw_dpath
   import lzwvw_pkg::*;
#(
   parameter int MAX_WIDTH  = 12,
   parameter int DICT_DEPTH = 4096,
   localparam int WW = $clog2(MAX_WIDTH + 1)
)(
   input  logic                 clock,
   input  logic                 reset,
   input  logic [7:0]           in_byte,
   input  logic                 in_fin,
   input  logic [WW-1:0]        limit,
   input  cmd_type              cmd,
   output status_type           status,
   input  logic                 rsp_tready,
   output logic                 rsp_tvalid,
   output logic [MAX_WIDTH-1:0] rsp_value,
   output logic [3:0]           rsp_bits,
   output logic [1:0]           rsp_kind,
   output logic                 rsp_last
);

   localparam int CIW  = $clog2(DICT_DEPTH);
   localparam int SW   = CIW + 1;
   localparam int KW   = MAX_WIDTH + 8;
   localparam int NW   = (CIW > MAX_WIDTH) ? CIW : MAX_WIDTH;
   localparam int NW1  = NW + 1;
   localparam int EW   = KW + SW;

   // Slot table holds codes; code table holds the key and owning slot of each code.
   // A slot counts as occupied only if its code is live and points back at it,
   // so a stream or dictionary reset needs no clearing pass.
   logic [CIW-1:0] slot_mem [2**SW];
   logic [EW-1:0]  code_mem [DICT_DEPTH];

   logic [7:0]           byte_ff;
   logic                 fin_ff;
   logic [MAX_WIDTH-1:0] prefix_ff, prefix_in;
   logic                 present_ff, present_in;
   logic [MAX_WIDTH-1:0] nfc_ff, nfc_in;
   logic [WW-1:0]        width_ff, width_in;
   logic [KW-1:0]        key_ff;
   logic [SW-1:0]        slot_ff;
   logic [CIW-1:0]       slot_data_ff;
   logic [EW-1:0]        code_data_ff;

   logic                 out_valid_ff, out_valid_in;
   logic [MAX_WIDTH-1:0] out_value_ff;
   logic [3:0]           out_bits_ff;
   logic [1:0]           out_kind_ff;
   logic                 out_last_ff;

   logic [KW-1:0]        key_new;
   logic [SW-1:0]        home_slot;
   logic [MAX_WIDTH-1:0] grow_point;
   logic [MAX_WIDTH-1:0] nfc_inc;
   logic                 at_grow;
   logic                 slot_valid;
   logic                 key_match;
   logic                 out_free;

   assign key_new   = {prefix_ff, byte_ff};
   assign home_slot = key_new[SW-1:0] ^ SW'(key_new >> SW);
   assign grow_point = {MAX_WIDTH{1'b1}} >> (WW'(MAX_WIDTH) - width_ff);
   assign nfc_inc   = nfc_ff + MAX_WIDTH'(1);
   assign at_grow   = (nfc_inc == grow_point);
   assign out_free  = !out_valid_ff || rsp_tready;
   assign key_match = (code_data_ff[EW-1:SW] == key_ff);

   always_comb begin
      if ((NW'(slot_data_ff) >= NW'(FIRST_FREE)) && (NW'(slot_data_ff) < NW'(nfc_ff))
          && (code_data_ff[SW-1:0] == slot_ff)) begin
         slot_valid = 1'b1;
      end else begin
         slot_valid = 1'b0;
      end
   end

   assign status.present    = present_ff;
   assign status.fin        = fin_ff;
   assign status.hit        = slot_valid && key_match;
   assign status.empty      = !slot_valid;
   assign status.will_clear = at_grow && !(width_ff < limit);
   assign status.out_free   = out_free;

   always_comb begin
      prefix_in  = prefix_ff;
      present_in = present_ff;
      nfc_in     = nfc_ff;
      width_in   = width_ff;
      if (cmd.first) begin
         prefix_in  = MAX_WIDTH'(byte_ff);
         present_in = 1'b1;
      end
      if (cmd.take_hit) begin
         prefix_in = MAX_WIDTH'(slot_data_ff);
      end
      if (cmd.insert) begin
         prefix_in = MAX_WIDTH'(byte_ff);
         nfc_in    = nfc_inc;
         if (at_grow) begin
            if (width_ff < limit) begin
               width_in = width_ff + WW'(1);
            end else begin
               nfc_in = MAX_WIDTH'(FIRST_FREE);
            end
         end
      end
      if (cmd.restart) begin
         prefix_in  = '0;
         present_in = 1'b0;
         nfc_in     = MAX_WIDTH'(FIRST_FREE);
         width_in   = WW'(START_WIDTH);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_ff  <= '0;
         present_ff <= 1'b0;
         nfc_ff     <= MAX_WIDTH'(FIRST_FREE);
         width_ff   <= WW'(START_WIDTH);
      end else begin
         prefix_ff  <= prefix_in;
         present_ff <= present_in;
         nfc_ff     <= nfc_in;
         width_ff   <= width_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         byte_ff <= in_byte;
         fin_ff  <= in_fin;
      end
      if (cmd.probe) begin
         key_ff  <= key_new;
         slot_ff <= home_slot;
      end
      if (cmd.next_slot) begin
         slot_ff <= slot_ff + SW'(1);
      end
   end

   // Dictionary memories; no insert once the next code reaches the table depth.
   always_ff @(posedge clock) begin
      if (cmd.slot_rd) begin
         slot_data_ff <= slot_mem[slot_ff];
      end
      if (cmd.code_rd) begin
         code_data_ff <= code_mem[slot_data_ff];
      end
      if (cmd.insert && (NW1'(nfc_ff) < NW1'(DICT_DEPTH))) begin
         slot_mem[slot_ff]        <= CIW'(nfc_ff);
         code_mem[CIW'(nfc_ff)]   <= {key_ff, slot_ff};
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_tready;
      if (cmd.emit != EMIT_NONE) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit != EMIT_NONE) begin
         out_bits_ff <= 4'(width_ff);
         out_last_ff <= cmd.emit_last;
      end
      unique case (cmd.emit)
         EMIT_PREFIX: begin
            out_value_ff <= prefix_ff;
            out_kind_ff  <= KIND_DATA;
         end
         EMIT_RESET: begin
            out_value_ff <= grow_point - MAX_WIDTH'(1);
            out_kind_ff  <= KIND_RESET;
         end
         EMIT_END: begin
            out_value_ff <= grow_point;
            out_kind_ff  <= KIND_END;
         end
         default: begin
         end
      endcase
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_value  = out_value_ff;
   assign rsp_bits   = out_bits_ff;
   assign rsp_kind   = out_kind_ff;
   assign rsp_last   = out_last_ff;

endmodule

@@ tb/sv/lzw_variable_width_compressor_tb.sv @@
// Self-checking testbench for the variable code width LZW compressor.
module testbench;
   import lzwvw_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [11:0] code;
      logic [3:0]  bits;
      logic [1:0]  kind;
      logic        last;
   } code_type;

   // directed stimulus row; typed rows carry their codes, others use the predictor
   typedef struct {
      logic [7:0] data;
      logic       fin;
      int         n_typed;
      code_type   c0;
      code_type   c1;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;   // code_value[11:0], code_bits[15:12]
   logic [1:0]  rsp_tuser;   // code_kind
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   lzw_variable_width_compressor u_top (.*);

   always #1 clock = ~clock;

   // predictor state
   logic [11:0] pfx;
   logic        pfx_valid;
   int          free_code;
   int          cur_w;
   logic [3:0]  width_limit;
   int          dict[int];        // {prefix, byte} -> learned code

   code_type    pending_codes[$];
   code_type    step_codes[$];
   int          mismatches = 0;
   int          codes_seen = 0;
   int          resets_seen = 0;
   int          ends_seen = 0;
   int          bytes_sent = 0;
   int          idle_mode = 0;    // 0: sender light, sink heavy; 1: swapped; 2: none
   logic        hold_req = 1'b0;
   logic        hold_done = 1'b0;
   int          hold_cnt = 0;

   function automatic code_type mk(int v, int w, logic [1:0] k, logic l);
      code_type c;
      c.code = v[11:0];
      c.bits = w[3:0];
      c.kind = k;
      c.last = l;
      return c;
   endfunction

   function automatic void stream_clear();
      dict.delete();
      pfx = '0;
      pfx_valid = 1'b0;
      free_code = FIRST_FREE;
      cur_w = START_WIDTH;
   endfunction

   // Expected codes for one input byte, left in step_codes.
   function automatic void lzw_predict(logic [7:0] b, logic fin);
      int lim;
      int key;
      lim = width_limit;
      if (lim < START_WIDTH) lim = START_WIDTH;
      if (lim > 12) lim = 12;
      step_codes.delete();
      if (!pfx_valid) begin
         pfx = {4'd0, b};
         pfx_valid = 1'b1;
      end else begin
         key = {pfx, b};
         if (dict.exists(key)) begin
            pfx = dict[key][11:0];
         end else begin
            step_codes.push_back(mk(pfx, cur_w, KIND_DATA, 1'b0));
            if (free_code < 4096) dict[key] = free_code;
            free_code++;
            pfx = {4'd0, b};
            if (free_code == (1 << cur_w) - 1) begin
               if (cur_w < lim) begin
                  cur_w++;
               end else begin
                  // dictionary full at the width limit: clear and send reset code
                  dict.delete();
                  free_code = FIRST_FREE;
                  step_codes.push_back(mk((1 << cur_w) - 2, cur_w, KIND_RESET, 1'b0));
               end
            end
         end
      end
      if (fin) begin
         step_codes.push_back(mk(pfx, cur_w, KIND_DATA, 1'b0));
         step_codes.push_back(mk((1 << cur_w) - 1, cur_w, KIND_END, 1'b0));
         stream_clear();
      end
      if (step_codes.size() > 0) step_codes[step_codes.size()-1].last = 1'b1;
   endfunction

   // Offer one byte, wait for the transaction, then queue what it should produce.
   task automatic send_byte(logic [7:0] b, logic fin, int n_typed = 0,
                            code_type c0 = '0, code_type c1 = '0);
      int pct;
      pct = (idle_mode == 0) ? 10 : (idle_mode == 1) ? 78 : 0;
      if ($urandom_range(99) < pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < pct) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= fin;
      do @(posedge clock); while (!req_tready);
      lzw_predict(b, fin);
      if (n_typed > 0) begin
         pending_codes.push_back(c0);
         if (n_typed > 1) pending_codes.push_back(c1);
      end else begin
         foreach (step_codes[i]) pending_codes.push_back(step_codes[i]);
      end
      bytes_sent++;
      if (bytes_sent == 150) hold_req <= 1'b1;
   endtask

   // Let the block settle; bytes that produce no code may still be in flight.
   task automatic drain();
      req_tvalid <= 1'b0;
      req_tlast <= 1'b0;
      while (pending_codes.size() > 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic csr_write(logic [3:0] v);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= {28'd0, v};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      width_limit = v;
   endtask

   task automatic random_stream(int n, int alpha);
      for (int i = 0; i < n; i++)
         send_byte(alpha >= 255 ? 8'($urandom_range(255)) : 8'($urandom_range(alpha)),
                   i == n - 1);
   endtask

   // Sink: random backpressure plus one long hold-off so the block backs up.
   always @(posedge clock) begin
      if (hold_req && !hold_done) begin
         hold_done <= 1'b1;
         hold_cnt <= 400;
         rsp_tready <= 1'b0;
      end else if (hold_cnt > 0) begin
         hold_cnt <= hold_cnt - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= ((idle_mode == 0) ? 78 :
                                              (idle_mode == 1) ? 10 : 0));
      end
   end

   // Result checker: each code transaction against the oldest expectation.
   always @(posedge clock) begin
      code_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = mk(rsp_tdata[11:0], rsp_tdata[15:12], rsp_tuser, rsp_tlast);
         codes_seen++;
         if (got.kind == KIND_RESET) resets_seen++;
         if (got.kind == KIND_END) ends_seen++;
         if (pending_codes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected code: code=%h bits=%0d kind=%0d last=%b",
                        got.code, got.bits, got.kind, got.last);
         end else begin
            want = pending_codes.pop_front();
            if (got != want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp %h/%0d/%0d/%b got %h/%0d/%0d/%b",
                           want.code, want.bits, want.kind, want.last,
                           got.code, got.bits, got.kind, got.last);
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("lzw_variable_width_compressor test failed");
      $finish;
   end

   initial begin
      row_type rows[$];
      string   pat;
      width_limit = 4'd12;
      stream_clear();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // lone final bytes give flush code then end code 511 at width 9
      rows.push_back('{8'h41, 1'b1, 2, mk('h41, 9, KIND_DATA, 0), mk(511, 9, KIND_END, 1)});
      rows.push_back('{8'hFF, 1'b1, 2, mk('hFF, 9, KIND_DATA, 0), mk(511, 9, KIND_END, 1)});
      rows.push_back('{8'h00, 1'b1, 2, mk('h00, 9, KIND_DATA, 0), mk(511, 9, KIND_END, 1)});
      // repeated pairs exercise dictionary hits and prefix extension
      pat = "ABABABAB";
      foreach (pat[i]) rows.push_back('{pat[i], 1'b0, 0, '0, '0});
      rows.push_back('{8'h42, 1'b1, 0, '0, '0});
      for (int i = 0; i < 6; i++) rows.push_back('{8'h55, i == 5, 0, '0, '0});
      rows.push_back('{8'h00, 1'b0, 0, '0, '0});
      rows.push_back('{8'hFF, 1'b0, 0, '0, '0});
      rows.push_back('{8'h80, 1'b0, 0, '0, '0});
      rows.push_back('{8'h7F, 1'b1, 0, '0, '0});
      foreach (rows[i]) send_byte(rows[i].data, rows[i].fin, rows[i].n_typed,
                                  rows[i].c0, rows[i].c1);
      drain();

      // smallest width limit, one random stream
      csr_write(4'd9);
      random_stream(60, 255);
      drain();

      // out-of-range high limit, then limit lowered while the stream stays open
      idle_mode = 1;
      csr_write(4'd15);
      for (int i = 0; i < 40; i++) send_byte(8'($urandom_range(255)), 1'b0);
      drain();
      csr_write(4'd3);
      random_stream(30, 255);
      drain();

      // default limit, short streams over a small alphabet (many hits), then over all byte values
      idle_mode = 2;
      csr_write(4'd12);
      for (int s = 0; s < 4; s++) random_stream($urandom_range(1, 8), 3);
      for (int s = 0; s < 2; s++) random_stream($urandom_range(1, 6), 255);
      drain();

      $display("sent %0d bytes, checked %0d codes (%0d dictionary resets, %0d end codes)",
               bytes_sent, codes_seen, resets_seen, ends_seen);
      $display("covered lone final bytes, hit-heavy runs, limits 9 and 12, clamped 15/3");
      $display("with a limit change inside an open stream, and one long sink stall");
      if (mismatches == 0 && pending_codes.size() == 0) begin
         $display("lzw_variable_width_compressor test passed");
      end else begin
         $display("lzw_variable_width_compressor test failed");
      end
      $finish;
   end

endmodule
